// ===== rtl/crct_pkg.sv =====
// crct_pkg: shared types, codes and widths of the convex region containment test unit
// used by crct_ctrl, crct_datapath and convex_region_containment_test_unit; no dependencies
`default_nettype none

package crct_pkg;

    // default table depth
    localparam int MAX_PLANES_DEF = 64;

    // transaction op codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_POINT  = 2'd2;
    localparam logic [1:0] OP_SPHERE = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_DEGEN = 2'd2;

    // datapath widths
    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;
    localparam int EM_W    = 33;   // edge magnitude
    localparam int MUL_W   = 33;   // multiplier operand
    localparam int ACC_W   = 64;
    localparam int CM_W    = 62;   // cross product magnitude
    localparam int NRM_W   = 24;   // normalised magnitude
    localparam int SQ_W    = 52;   // square root remainder and root
    localparam int SQB_W   = 51;   // square root trial bit
    localparam int LEN_W   = 25;
    localparam int DIV_W   = 42;
    localparam int N_W     = 18;   // Q2.16 normal
    localparam int ENTRY_W = 3 * N_W + COORD_W;

    // iteration counts of the serial units
    localparam int SQRT_STEPS = 26;
    localparam int DIV_STEPS  = 18;

    // multiplier operand selects
    localparam logic [3:0] MS_X0   = 4'd0;
    localparam logic [3:0] MS_X1   = 4'd1;
    localparam logic [3:0] MS_X2   = 4'd2;
    localparam logic [3:0] MS_X3   = 4'd3;
    localparam logic [3:0] MS_X4   = 4'd4;
    localparam logic [3:0] MS_X5   = 4'd5;
    localparam logic [3:0] MS_SQ0  = 4'd6;
    localparam logic [3:0] MS_SQ1  = 4'd7;
    localparam logic [3:0] MS_SQ2  = 4'd8;
    localparam logic [3:0] MS_OF0  = 4'd9;
    localparam logic [3:0] MS_OF1  = 4'd10;
    localparam logic [3:0] MS_OF2  = 4'd11;
    localparam logic [3:0] MS_TS0  = 4'd12;
    localparam logic [3:0] MS_TS1  = 4'd13;
    localparam logic [3:0] MS_TS2  = 4'd14;

    // datapath commands
    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_EDGE_SHIFT,
        DP_MUL,
        DP_ACC_FIRST,
        DP_ACC_NEXT,
        DP_CR_SAVE,
        DP_NORM_SHIFT,
        DP_ZERO_PLANE,
        DP_SQRT_INIT,
        DP_SQRT_STEP,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_DIV_SAVE,
        DP_OFF_FIN,
        DP_PLANE_WRITE,
        DP_COUNT_CLEAR,
        DP_COMPARE
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [3:0] sel;
    } dp_cmd_t;

    typedef struct packed {
        logic edge_big;
        logic norm_big;
        logic norm_small;
        logic norm_zero;
        logic plane_full;
        logic plane_empty;
        logic hit;
        logic last;
    } dp_stat_t;

    typedef struct packed {
        logic       load;
        logic       in_region;
        logic [1:0] status;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/crct_datapath.sv =====
// crct_datapath: plane table, shared multiplier, accumulator, square root and divider
// depends on crct_pkg; driven by crct_ctrl through dp_cmd_t
`default_nettype none

module crct_datapath
    import crct_pkg::*;
#(
    parameter int MAX_PLANES = MAX_PLANES_DEF,
    parameter int CNT_W      = $clog2(MAX_PLANES + 1)
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire dp_cmd_t                   cmd,
    output dp_stat_t                       stat,
    output logic [CNT_W-1:0]               count,
    input  wire logic signed [COORD_W-1:0] in_ax,
    input  wire logic signed [COORD_W-1:0] in_ay,
    input  wire logic signed [COORD_W-1:0] in_az,
    input  wire logic signed [COORD_W-1:0] in_bx,
    input  wire logic signed [COORD_W-1:0] in_by,
    input  wire logic signed [COORD_W-1:0] in_bz,
    input  wire logic signed [COORD_W-1:0] in_cx,
    input  wire logic signed [COORD_W-1:0] in_cy,
    input  wire logic signed [COORD_W-1:0] in_cz,
    input  wire logic [RAD_W-1:0]          in_radius,
    input  wire logic [1:0]                in_op
);

    localparam int IDX_W = $clog2(MAX_PLANES);

    // operand registers
    logic signed [COORD_W-1:0] a_reg [3];
    logic [2:0]                e_sgn_reg, f_sgn_reg;
    logic [EM_W-1:0]           e_mag_reg [3];
    logic [EM_W-1:0]           f_mag_reg [3];
    logic signed [ACC_W-1:0]   limit_reg;
    logic [CM_W-1:0]           cm_reg [3];
    logic [2:0]                cn_reg;
    logic signed [ACC_W-1:0]   prod_reg;
    logic                      prod_neg_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [SQ_W-1:0]           rad_reg, root_reg;
    logic [SQB_W-1:0]          bit_reg;
    logic [DIV_W-1:0]          rem_reg, dvs_reg;
    logic [N_W-1:0]            q_reg;
    logic signed [N_W-1:0]     n_reg [3];
    logic signed [COORD_W-1:0] off_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [IDX_W-1:0]          rd_idx_reg;

    // plane table
    logic [ENTRY_W-1:0] mem [MAX_PLANES];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic signed [N_W-1:0]     rd_n [3];
    logic signed [COORD_W-1:0] rd_off;

    assign rd_n[0] = rd_data_reg[ENTRY_W-1 -: N_W];
    assign rd_n[1] = rd_data_reg[ENTRY_W-1-N_W -: N_W];
    assign rd_n[2] = rd_data_reg[ENTRY_W-1-2*N_W -: N_W];
    assign rd_off  = rd_data_reg[COORD_W-1:0];

    // edge differences at load
    logic signed [EM_W-1:0] ed [3];
    logic signed [EM_W-1:0] fd [3];
    logic signed [COORD_W-1:0] in_a [3];
    logic signed [COORD_W-1:0] in_b [3];
    logic signed [COORD_W-1:0] in_c [3];

    assign in_a[0] = in_ax;
    assign in_a[1] = in_ay;
    assign in_a[2] = in_az;
    assign in_b[0] = in_bx;
    assign in_b[1] = in_by;
    assign in_b[2] = in_bz;
    assign in_c[0] = in_cx;
    assign in_c[1] = in_cy;
    assign in_c[2] = in_cz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ed[i] = {in_b[i][COORD_W-1], in_b[i]} - {in_a[i][COORD_W-1], in_a[i]};
            fd[i] = {in_c[i][COORD_W-1], in_c[i]} - {in_a[i][COORD_W-1], in_a[i]};
        end
    end

    // multiplier operand select
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic                      mul_neg;
    logic signed [2*MUL_W-1:0] mul_full;

    function automatic logic signed [MUL_W-1:0] emx(input logic [EM_W-1:0] m);
        emx = {3'b000, m[29:0]};
    endfunction

    function automatic logic signed [MUL_W-1:0] nx(input logic [N_W-1:0] n);
        nx = {{(MUL_W-N_W){n[N_W-1]}}, n};
    endfunction

    function automatic logic signed [MUL_W-1:0] ax(input logic [COORD_W-1:0] a);
        ax = {a[COORD_W-1], a};
    endfunction

    function automatic logic signed [MUL_W-1:0] cmx(input logic [CM_W-1:0] c);
        cmx = {{(MUL_W-NRM_W){1'b0}}, c[NRM_W-1:0]};
    endfunction

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (cmd.sel)
            // cross product terms, odd ones subtracted
            MS_X0: begin
                mul_a = emx(e_mag_reg[1]); mul_b = emx(f_mag_reg[2]);
                mul_neg = e_sgn_reg[1] ^ f_sgn_reg[2];
            end
            MS_X1: begin
                mul_a = emx(e_mag_reg[2]); mul_b = emx(f_mag_reg[1]);
                mul_neg = ~(e_sgn_reg[2] ^ f_sgn_reg[1]);
            end
            MS_X2: begin
                mul_a = emx(e_mag_reg[2]); mul_b = emx(f_mag_reg[0]);
                mul_neg = e_sgn_reg[2] ^ f_sgn_reg[0];
            end
            MS_X3: begin
                mul_a = emx(e_mag_reg[0]); mul_b = emx(f_mag_reg[2]);
                mul_neg = ~(e_sgn_reg[0] ^ f_sgn_reg[2]);
            end
            MS_X4: begin
                mul_a = emx(e_mag_reg[0]); mul_b = emx(f_mag_reg[1]);
                mul_neg = e_sgn_reg[0] ^ f_sgn_reg[1];
            end
            MS_X5: begin
                mul_a = emx(e_mag_reg[1]); mul_b = emx(f_mag_reg[0]);
                mul_neg = ~(e_sgn_reg[1] ^ f_sgn_reg[0]);
            end
            // squares of normalised magnitudes
            MS_SQ0: begin mul_a = cmx(cm_reg[0]); mul_b = cmx(cm_reg[0]); end
            MS_SQ1: begin mul_a = cmx(cm_reg[1]); mul_b = cmx(cm_reg[1]); end
            MS_SQ2: begin mul_a = cmx(cm_reg[2]); mul_b = cmx(cm_reg[2]); end
            // negated normal dot first vertex
            MS_OF0: begin mul_a = nx(n_reg[0]); mul_b = ax(a_reg[0]); mul_neg = 1'b1; end
            MS_OF1: begin mul_a = nx(n_reg[1]); mul_b = ax(a_reg[1]); mul_neg = 1'b1; end
            MS_OF2: begin mul_a = nx(n_reg[2]); mul_b = ax(a_reg[2]); mul_neg = 1'b1; end
            // stored normal dot query point
            MS_TS0: begin mul_a = nx(rd_n[0]); mul_b = ax(a_reg[0]); end
            MS_TS1: begin mul_a = nx(rd_n[1]); mul_b = ax(a_reg[1]); end
            MS_TS2: begin mul_a = nx(rd_n[2]); mul_b = ax(a_reg[2]); end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // accumulator term with optional negation via carry in
    logic signed [ACC_W-1:0] acc_term, acc_base, acc_sum;

    assign acc_term = prod_neg_reg ? ~prod_reg : prod_reg;
    assign acc_base = (cmd.op == DP_ACC_FIRST) ? '0 : acc_reg;
    assign acc_sum  = acc_base + acc_term + {{(ACC_W-1){1'b0}}, prod_neg_reg};

    // magnitude selection for divide init
    logic [CM_W-1:0] cm_pick;

    always_comb begin
        case (cmd.sel[1:0])
            2'd0:    cm_pick = cm_reg[0];
            2'd1:    cm_pick = cm_reg[1];
            default: cm_pick = cm_reg[2];
        endcase
    end

    // square root trial
    logic [SQ_W-1:0] sq_trial;
    assign sq_trial = root_reg + {1'b0, bit_reg};

    // accumulator magnitude for cross save and offset
    logic [ACC_W-1:0] acc_mag;
    logic [ACC_W-1:0] off_round;
    logic [ACC_W-1:0] off_r;
    logic [COORD_W-1:0] off_sat;

    assign acc_mag   = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign off_round = acc_mag + ACC_W'(1 << 15);
    assign off_r     = off_round >> 16;

    always_comb begin
        if (acc_reg[ACC_W-1]) begin
            if (off_r > ACC_W'(64'h8000_0000)) off_sat = 32'h8000_0000;
            else                               off_sat = COORD_W'(-off_r[COORD_W-1:0]);
        end else begin
            if (off_r > ACC_W'(64'h7FFF_FFFF)) off_sat = 32'h7FFF_FFFF;
            else                               off_sat = off_r[COORD_W-1:0];
        end
    end

    // plane distance against limit
    logic signed [ACC_W-1:0] plane_dist;
    assign plane_dist = acc_reg + {{16{rd_off[COORD_W-1]}}, rd_off, 16'h0000};

    // status towards the controller
    always_comb begin
        stat.edge_big    = 1'b0;
        stat.norm_big    = 1'b0;
        stat.norm_small  = 1'b1;
        stat.norm_zero   = 1'b1;
        for (int i = 0; i < 3; i++) begin
            stat.edge_big   = stat.edge_big | (|e_mag_reg[i][EM_W-1:30])
                                            | (|f_mag_reg[i][EM_W-1:30]);
            stat.norm_big   = stat.norm_big | (|cm_reg[i][CM_W-1:NRM_W]);
            stat.norm_small = stat.norm_small & ~(|cm_reg[i][CM_W-1:NRM_W-1]);
            stat.norm_zero  = stat.norm_zero & ~(|cm_reg[i]);
        end
        stat.plane_full  = (count_reg == CNT_W'(MAX_PLANES));
        stat.plane_empty = (count_reg == '0);
        stat.hit         = (plane_dist > limit_reg);
        stat.last        = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);
    end

    assign count = count_reg;

    // plane count and read pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            rd_idx_reg <= '0;
        end else begin
            case (cmd.op)
                DP_COUNT_CLEAR: count_reg  <= '0;
                DP_PLANE_WRITE: count_reg  <= count_reg + CNT_W'(1);
                DP_LOAD:        rd_idx_reg <= '0;
                DP_COMPARE:     rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                default: ;
            endcase
        end
    end

    // table write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.op == DP_PLANE_WRITE) begin
            mem[count_reg[IDX_W-1:0]] <= {n_reg[0], n_reg[1], n_reg[2], off_reg};
        end
        rd_data_reg <= mem[rd_idx_reg];
    end

    // arithmetic registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    a_reg[i]     <= in_a[i];
                    e_sgn_reg[i] <= ed[i][EM_W-1];
                    f_sgn_reg[i] <= fd[i][EM_W-1];
                    e_mag_reg[i] <= ed[i][EM_W-1] ? EM_W'(-ed[i]) : EM_W'(ed[i]);
                    f_mag_reg[i] <= fd[i][EM_W-1] ? EM_W'(-fd[i]) : EM_W'(fd[i]);
                end
                if (in_op == OP_SPHERE) limit_reg <= {17'h0, in_radius, 16'h0000};
                else                    limit_reg <= '0;
            end
            DP_EDGE_SHIFT: begin
                for (int i = 0; i < 3; i++) begin
                    e_mag_reg[i] <= e_mag_reg[i] >> 1;
                    f_mag_reg[i] <= f_mag_reg[i] >> 1;
                end
            end
            DP_MUL: begin
                prod_reg     <= mul_full[ACC_W-1:0];
                prod_neg_reg <= mul_neg;
            end
            DP_ACC_FIRST, DP_ACC_NEXT: acc_reg <= acc_sum;
            DP_CR_SAVE: begin
                case (cmd.sel[1:0])
                    2'd0:    begin cm_reg[0] <= acc_mag[CM_W-1:0]; cn_reg[0] <= acc_reg[ACC_W-1]; end
                    2'd1:    begin cm_reg[1] <= acc_mag[CM_W-1:0]; cn_reg[1] <= acc_reg[ACC_W-1]; end
                    default: begin cm_reg[2] <= acc_mag[CM_W-1:0]; cn_reg[2] <= acc_reg[ACC_W-1]; end
                endcase
            end
            DP_NORM_SHIFT: begin
                for (int i = 0; i < 3; i++) begin
                    if (stat.norm_big) cm_reg[i] <= cm_reg[i] >> 1;
                    else               cm_reg[i] <= cm_reg[i] << 1;
                end
            end
            DP_ZERO_PLANE: begin
                for (int i = 0; i < 3; i++) n_reg[i] <= '0;
                off_reg <= '0;
            end
            DP_SQRT_INIT: begin
                rad_reg  <= acc_reg[SQ_W-1:0];
                root_reg <= '0;
                bit_reg  <= {1'b1, {(SQB_W-1){1'b0}}};
            end
            DP_SQRT_STEP: begin
                if (rad_reg >= sq_trial) begin
                    rad_reg  <= rad_reg - sq_trial;
                    root_reg <= (root_reg >> 1) + {1'b0, bit_reg};
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            DP_DIV_INIT: begin
                rem_reg <= {2'b00, cm_pick[NRM_W-1:0], 16'h0000}
                         + DIV_W'(root_reg[LEN_W-1:1]);
                dvs_reg <= {root_reg[LEN_W-1:0], 17'h00000};
                q_reg   <= '0;
            end
            DP_DIV_STEP: begin
                if (rem_reg >= dvs_reg) begin
                    rem_reg <= rem_reg - dvs_reg;
                    q_reg   <= {q_reg[N_W-2:0], 1'b1};
                end else begin
                    q_reg   <= {q_reg[N_W-2:0], 1'b0};
                end
                dvs_reg <= dvs_reg >> 1;
            end
            DP_DIV_SAVE: begin
                case (cmd.sel[1:0])
                    2'd0:    n_reg[0] <= cn_reg[0] ? N_W'(-q_reg) : q_reg;
                    2'd1:    n_reg[1] <= cn_reg[1] ? N_W'(-q_reg) : q_reg;
                    default: n_reg[2] <= cn_reg[2] ? N_W'(-q_reg) : q_reg;
                endcase
            end
            DP_OFF_FIN: off_reg <= off_sat;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/crct_ctrl.sv =====
// crct_ctrl: state machine sequencing clear, add-triangle and containment tests
// depends on crct_pkg; commands crct_datapath
`default_nettype none

module crct_ctrl
    import crct_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] in_op,
    input  wire logic       out_busy,
    input  wire dp_stat_t   stat,
    output dp_cmd_t         cmd,
    output res_t            res
);

    typedef enum logic [23:0] {
        S_IDLE      = 24'h000001,
        S_CLEAR     = 24'h000002,
        S_EDGE      = 24'h000004,
        S_XMUL      = 24'h000008,
        S_XACC      = 24'h000010,
        S_XSAVE     = 24'h000020,
        S_NORM      = 24'h000040,
        S_ZERO      = 24'h000080,
        S_SQMUL     = 24'h000100,
        S_SQACC     = 24'h000200,
        S_SQRT_INIT = 24'h000400,
        S_SQRT      = 24'h000800,
        S_DIV_INIT  = 24'h001000,
        S_DIV       = 24'h002000,
        S_DIV_SAVE  = 24'h004000,
        S_OMUL      = 24'h008000,
        S_OACC      = 24'h010000,
        S_OFIN      = 24'h020000,
        S_WRITE     = 24'h040000,
        S_RD        = 24'h080000,
        S_TMUL      = 24'h100000,
        S_TACC      = 24'h200000,
        S_TCMP      = 24'h400000,
        S_DONE      = 24'h800000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] j_reg, j_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       inside_reg, inside_next;
    logic [1:0] status_reg, status_next;

    // next state and command decode
    always_comb begin
        state_next    = state_reg;
        j_next        = j_reg;
        cnt_next      = cnt_reg;
        inside_next   = inside_reg;
        status_next   = status_reg;
        cmd.op        = DP_NOP;
        cmd.sel       = '0;
        s_ready       = 1'b0;
        res.load      = 1'b0;
        res.in_region = inside_reg;
        res.status    = status_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op      = DP_LOAD;
                    inside_next = 1'b0;
                    status_next = ST_OK;
                    j_next      = '0;
                    case (in_op)
                        OP_CLEAR: state_next = S_CLEAR;
                        OP_ADD: begin
                            if (stat.plane_full) begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end else begin
                                state_next  = S_EDGE;
                            end
                        end
                        default: begin
                            if (stat.plane_empty) begin
                                inside_next = 1'b1;
                                state_next  = S_DONE;
                            end else begin
                                state_next  = S_RD;
                            end
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                cmd.op     = DP_COUNT_CLEAR;
                state_next = S_DONE;
            end
            // bring edges below 2^30
            S_EDGE: begin
                if (stat.edge_big) cmd.op = DP_EDGE_SHIFT;
                else               state_next = S_XMUL;
            end
            // cross product, two terms per component
            S_XMUL: begin
                cmd.op     = DP_MUL;
                cmd.sel    = MS_X0 + {1'b0, j_reg};
                state_next = S_XACC;
            end
            S_XACC: begin
                cmd.op = j_reg[0] ? DP_ACC_NEXT : DP_ACC_FIRST;
                if (j_reg[0]) begin
                    state_next = S_XSAVE;
                end else begin
                    j_next     = j_reg + 3'd1;
                    state_next = S_XMUL;
                end
            end
            S_XSAVE: begin
                cmd.op  = DP_CR_SAVE;
                cmd.sel = {2'b00, j_reg[2:1]};
                if (j_reg == 3'd5) begin
                    state_next = S_NORM;
                end else begin
                    j_next     = j_reg + 3'd1;
                    state_next = S_XMUL;
                end
            end
            // one bit of normalising shift per cycle
            S_NORM: begin
                j_next = '0;
                if (stat.norm_zero) begin
                    state_next = S_ZERO;
                end else if (stat.norm_big || stat.norm_small) begin
                    cmd.op = DP_NORM_SHIFT;
                end else begin
                    state_next = S_SQMUL;
                end
            end
            S_ZERO: begin
                cmd.op      = DP_ZERO_PLANE;
                status_next = ST_DEGEN;
                state_next  = S_WRITE;
            end
            // sum of squares
            S_SQMUL: begin
                cmd.op     = DP_MUL;
                cmd.sel    = MS_SQ0 + {1'b0, j_reg};
                state_next = S_SQACC;
            end
            S_SQACC: begin
                cmd.op = (j_reg == '0) ? DP_ACC_FIRST : DP_ACC_NEXT;
                if (j_reg == 3'd2) begin
                    state_next = S_SQRT_INIT;
                end else begin
                    j_next     = j_reg + 3'd1;
                    state_next = S_SQMUL;
                end
            end
            S_SQRT_INIT: begin
                cmd.op     = DP_SQRT_INIT;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                cmd.op   = DP_SQRT_STEP;
                cnt_next = cnt_reg + 5'd1;
                j_next   = '0;
                if (cnt_reg == 5'(SQRT_STEPS - 1)) state_next = S_DIV_INIT;
            end
            // one quotient bit per cycle, per component
            S_DIV_INIT: begin
                cmd.op     = DP_DIV_INIT;
                cmd.sel    = {1'b0, j_reg};
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.op   = DP_DIV_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1)) state_next = S_DIV_SAVE;
            end
            S_DIV_SAVE: begin
                cmd.op  = DP_DIV_SAVE;
                cmd.sel = {1'b0, j_reg};
                if (j_reg == 3'd2) begin
                    j_next     = '0;
                    state_next = S_OMUL;
                end else begin
                    j_next     = j_reg + 3'd1;
                    state_next = S_DIV_INIT;
                end
            end
            // plane offset
            S_OMUL: begin
                cmd.op     = DP_MUL;
                cmd.sel    = MS_OF0 + {1'b0, j_reg};
                state_next = S_OACC;
            end
            S_OACC: begin
                cmd.op = (j_reg == '0) ? DP_ACC_FIRST : DP_ACC_NEXT;
                if (j_reg == 3'd2) begin
                    state_next = S_OFIN;
                end else begin
                    j_next     = j_reg + 3'd1;
                    state_next = S_OMUL;
                end
            end
            S_OFIN: begin
                cmd.op     = DP_OFF_FIN;
                state_next = S_WRITE;
            end
            S_WRITE: begin
                cmd.op     = DP_PLANE_WRITE;
                state_next = S_DONE;
            end
            // plane walk for tests
            S_RD: begin
                j_next     = '0;
                state_next = S_TMUL;
            end
            S_TMUL: begin
                cmd.op     = DP_MUL;
                cmd.sel    = MS_TS0 + {1'b0, j_reg};
                state_next = S_TACC;
            end
            S_TACC: begin
                cmd.op = (j_reg == '0) ? DP_ACC_FIRST : DP_ACC_NEXT;
                if (j_reg == 3'd2) begin
                    state_next = S_TCMP;
                end else begin
                    j_next     = j_reg + 3'd1;
                    state_next = S_TMUL;
                end
            end
            S_TCMP: begin
                cmd.op = DP_COMPARE;
                if (stat.hit) begin
                    inside_next = 1'b0;
                    state_next  = S_DONE;
                end else if (stat.last) begin
                    inside_next = 1'b1;
                    state_next  = S_DONE;
                end else begin
                    state_next  = S_RD;
                end
            end
            // hand result to the output register
            S_DONE: begin
                if (!out_busy) begin
                    res.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        j_reg      <= j_next;
        cnt_reg    <= cnt_next;
        inside_reg <= inside_next;
        status_reg <= status_next;
    end

endmodule

`default_nettype wire

// ===== rtl/convex_region_containment_test_unit.sv =====
// convex_region_containment_test_unit: top level with output register
// depends on crct_pkg, crct_ctrl and crct_datapath
//
// Usage: one transaction on the s_ channel (valid/ready) carries an op code,
// three vertices and a sphere radius. Each transaction gives exactly one
// transaction on the m_ channel: is_inside, status and the plane count.
// Clear resets the plane count. Add runs edge scaling, cross product on the
// shared multiplier, normalising shift (one bit per cycle), sum of squares,
// bit-serial square root, three 18-step restoring divisions and the offset.
// A degenerate triangle goes from the normalising shift to the table write,
// storing a zero plane, and a full table answers without any computation.
// A test walks the stored planes in turn through the shared multiplier and
// the single read port of the plane table. Items are handled one at a time.
// A finished result waits in the output register while a new transaction is
// accepted; if the receiver stalls, the next result waits in the controller
// until the register frees. Reset empties the plane table (count to zero) and
// drops any pending result; table contents are not swept.
`default_nettype none

module convex_region_containment_test_unit
    import crct_pkg::*;
#(
    parameter int MAX_PLANES = MAX_PLANES_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [1:0]                s_op,
    input  wire logic signed [COORD_W-1:0] s_ax,
    input  wire logic signed [COORD_W-1:0] s_ay,
    input  wire logic signed [COORD_W-1:0] s_az,
    input  wire logic signed [COORD_W-1:0] s_bx,
    input  wire logic signed [COORD_W-1:0] s_by_coord,
    input  wire logic signed [COORD_W-1:0] s_bz,
    input  wire logic signed [COORD_W-1:0] s_cx,
    input  wire logic signed [COORD_W-1:0] s_cy,
    input  wire logic signed [COORD_W-1:0] s_cz,
    input  wire logic [RAD_W-1:0]          s_sphere_radius,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_is_inside,
    output logic [1:0]                     m_status,
    output logic [6:0]                     m_plane_total
);

    localparam int CNT_W = $clog2(MAX_PLANES + 1);

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    res_t             res;
    logic [CNT_W-1:0] count;
    logic             out_busy;

    logic             m_valid_reg;
    logic             is_inside_reg;
    logic [1:0]       status_reg;
    logic [6:0]       total_reg;
    logic [CNT_W+6:0] count_ext;

    assign out_busy  = m_valid_reg & ~m_ready;
    assign count_ext = {7'h00, count};

    crct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .in_op    (s_op),
        .out_busy (out_busy),
        .stat     (stat),
        .cmd      (cmd),
        .res      (res)
    );

    crct_datapath #(
        .MAX_PLANES (MAX_PLANES),
        .CNT_W      (CNT_W)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .count     (count),
        .in_ax     (s_ax),
        .in_ay     (s_ay),
        .in_az     (s_az),
        .in_bx     (s_bx),
        .in_by     (s_by_coord),
        .in_bz     (s_bz),
        .in_cx     (s_cx),
        .in_cy     (s_cy),
        .in_cz     (s_cz),
        .in_radius (s_sphere_radius),
        .in_op     (s_op)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res.load) begin
            is_inside_reg <= res.in_region;
            status_reg    <= res.status;
            total_reg     <= count_ext[6:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_is_inside   = is_inside_reg;
    assign m_status      = status_reg;
    assign m_plane_total = total_reg;

endmodule

`default_nettype wire

// ===== test/convex_region_containment_test_unit_tb.sv =====
// convex_region_containment_test_unit_tb: self-checking testbench of the containment unit
// random and directed plane table / point / sphere traffic against a scoreboard predictor
// depends on crct_pkg and convex_region_containment_test_unit
`default_nettype none

module convex_region_containment_test_unit_tb;
    import crct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH  = 64;
    localparam int IDLE_LIMIT   = 40000;
    localparam int DRAIN_CYCLES = 800;
    localparam int RANDOM_ITEMS = 2000;

    typedef struct {
        logic       in_region;
        logic [1:0] status;
        logic [6:0] total;
    } region_answer_t;

    // plane table model and store of expected answers
    class containment_scoreboard;
        longint         norm_x [TABLE_DEPTH];
        longint         norm_y [TABLE_DEPTH];
        longint         norm_z [TABLE_DEPTH];
        longint         offset [TABLE_DEPTH];
        int             plane_count;
        region_answer_t answer_q [$];
        int             mismatches;

        function new();
            plane_count = 0;
            mismatches  = 0;
        endfunction

        function longint unsigned magnitude(longint v);
            return (v < 0) ? longint'(0) - v : v;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned bitpos;
            root   = 0;
            bitpos = 64'd1 << 62;
            while (bitpos > v) bitpos >>= 2;
            while (bitpos != 0) begin
                if (v >= root + bitpos) begin
                    v    = v - (root + bitpos);
                    root = (root >> 1) + bitpos;
                end else begin
                    root = root >> 1;
                end
                bitpos >>= 2;
            end
            return root;
        endfunction

        // plane through three vertices; returns 1 when the triangle is degenerate
        function bit triangle_plane(longint p[9], output longint nrm[3]);
            longint          e [3];
            longint          f [3];
            longint          cr [3];
            longint unsigned cm [3];
            bit              cneg [3];
            longint unsigned m;
            longint unsigned len;
            longint unsigned q;
            int              k;
            m = 0;
            k = 0;
            for (int i = 0; i < 3; i++) begin
                nrm[i] = 0;
                e[i] = p[3+i] - p[i];
                f[i] = p[6+i] - p[i];
                if (magnitude(e[i]) > m) m = magnitude(e[i]);
                if (magnitude(f[i]) > m) m = magnitude(f[i]);
            end
            // bring edges below 2^30 so the cross product fits
            while ((m >> k) >= (64'd1 << 30)) k++;
            for (int i = 0; i < 3; i++) begin
                e[i] = (e[i] < 0) ? -longint'(magnitude(e[i]) >> k) : longint'(e[i] >> k);
                f[i] = (f[i] < 0) ? -longint'(magnitude(f[i]) >> k) : longint'(f[i] >> k);
            end
            cr[0] = e[1] * f[2] - e[2] * f[1];
            cr[1] = e[2] * f[0] - e[0] * f[2];
            cr[2] = e[0] * f[1] - e[1] * f[0];
            m = 0;
            for (int i = 0; i < 3; i++) begin
                cm[i]   = magnitude(cr[i]);
                cneg[i] = cr[i] < 0;
                if (cm[i] > m) m = cm[i];
            end
            if (m == 0) return 1'b1;
            // normalise largest component into [2^23, 2^24)
            while (m >= (64'd1 << 24)) begin
                m >>= 1;
                for (int i = 0; i < 3; i++) cm[i] >>= 1;
            end
            while (m < (64'd1 << 23)) begin
                m <<= 1;
                for (int i = 0; i < 3; i++) cm[i] <<= 1;
            end
            len = int_sqrt(cm[0] * cm[0] + cm[1] * cm[1] + cm[2] * cm[2]);
            for (int i = 0; i < 3; i++) begin
                q = ((cm[i] << 16) + (len >> 1)) / len;
                nrm[i] = cneg[i] ? -longint'(q) : longint'(q);
            end
            return 1'b0;
        endfunction

        // accepted input transaction: update table model and queue the answer
        function void note_input(logic [1:0] op, longint p[9], logic [RAD_W-1:0] radius);
            region_answer_t  ans;
            longint          nrm [3];
            longint          v;
            longint          off;
            longint          plane_dist;
            longint          limit;
            longint unsigned r;
            ans.in_region = 1'b0;
            ans.status    = ST_OK;
            if (op == OP_CLEAR) begin
                plane_count = 0;
            end else if (op == OP_ADD) begin
                if (plane_count >= TABLE_DEPTH) begin
                    ans.status = ST_FULL;
                end else begin
                    off = 0;
                    if (triangle_plane(p, nrm)) begin
                        ans.status = ST_DEGEN;
                    end else begin
                        v = -(nrm[0] * p[0] + nrm[1] * p[1] + nrm[2] * p[2]);
                        r = (magnitude(v) + (64'd1 << 15)) >> 16;
                        if (v < 0)
                            off = (r > 64'd2147483648) ? -64'sd2147483648 : -longint'(r);
                        else
                            off = (r > 64'd2147483647) ? 64'sd2147483647 : longint'(r);
                    end
                    norm_x[plane_count] = nrm[0];
                    norm_y[plane_count] = nrm[1];
                    norm_z[plane_count] = nrm[2];
                    offset[plane_count] = off;
                    plane_count++;
                end
            end else begin
                limit = (op == OP_SPHERE) ? (longint'(radius) <<< 16) : 0;
                ans.in_region = 1'b1;
                for (int i = 0; i < plane_count; i++) begin
                    plane_dist = norm_x[i] * p[0] + norm_y[i] * p[1] + norm_z[i] * p[2]
                               + (offset[i] <<< 16);
                    if (plane_dist > limit) begin
                        ans.in_region = 1'b0;
                        break;
                    end
                end
            end
            ans.total = plane_count[6:0];
            answer_q.push_back(ans);
        endfunction

        // accepted result transaction against the oldest expected answer
        function void check_result(logic is_in, logic [1:0] status, logic [6:0] total);
            region_answer_t ans;
            if (answer_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: inside %0d status %0d total %0d",
                             is_in, status, total);
                return;
            end
            ans = answer_q.pop_front();
            if (is_in !== ans.in_region || status !== ans.status || total !== ans.total) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected inside %0d status %0d total %0d, got %0d %0d %0d",
                             ans.in_region, ans.status, ans.total, is_in, status, total);
            end
        endfunction

        function int pending();
            return answer_q.size();
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [1:0]                s_op;
    logic signed [COORD_W-1:0] s_ax, s_ay, s_az, s_bx, s_by_coord, s_bz, s_cx, s_cy, s_cz;
    logic [RAD_W-1:0]          s_sphere_radius;
    logic                      m_valid;
    logic                      m_ready;
    logic                      m_is_inside;
    logic [1:0]                m_status;
    logic [6:0]                m_plane_total;

    containment_scoreboard sb;
    int src_idle_pct;
    int sink_stall_pct;
    int idle_cycles;

    convex_region_containment_test_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_ax            (s_ax),
        .s_ay            (s_ay),
        .s_az            (s_az),
        .s_bx            (s_bx),
        .s_by_coord      (s_by_coord),
        .s_bz            (s_bz),
        .s_cx            (s_cx),
        .s_cy            (s_cy),
        .s_cz            (s_cz),
        .s_sphere_radius (s_sphere_radius),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_inside     (m_is_inside),
        .m_status        (m_status),
        .m_plane_total   (m_plane_total)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: random stall driven at the rising edge
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // result side: check the transaction taken at the coming rising edge
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_is_inside, m_status, m_plane_total);
    end

    // watchdog on cycles with no transaction on either channel
    always @(negedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // coordinate mix: extremes, full range, and a small working box
    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: return 32'sh80000000;
                    1: return 32'sh7fffffff;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            1, 2: return $urandom;
            default: return int'($urandom_range(0, 4194304)) - 2097152;
        endcase
    endfunction

    function automatic logic [RAD_W-1:0] pick_radius();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return RAD_W'($urandom);
            default: return RAD_W'($urandom_range(0, 2097152));
        endcase
    endfunction

    // one input transaction, with optional sender idle before it
    task automatic send_item(input logic [1:0] op, input longint p[9],
                             input logic [RAD_W-1:0] radius);
        logic took;
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < src_idle_pct) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_op            <= op;
        s_ax            <= COORD_W'(p[0]);
        s_ay            <= COORD_W'(p[1]);
        s_az            <= COORD_W'(p[2]);
        s_bx            <= COORD_W'(p[3]);
        s_by_coord      <= COORD_W'(p[4]);
        s_bz            <= COORD_W'(p[5]);
        s_cx            <= COORD_W'(p[6]);
        s_cy            <= COORD_W'(p[7]);
        s_cz            <= COORD_W'(p[8]);
        s_sphere_radius <= radius;
        // ready is sampled mid-cycle, ahead of the edge that takes the transaction
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        sb.note_input(op, p, radius);
    endtask

    task automatic send_random_item();
        longint     p[9];
        int         pick;
        logic [1:0] op;
        pick = $urandom_range(99);
        for (int i = 0; i < 9; i++) p[i] = pick_coord();
        if (pick < 7)       op = OP_CLEAR;
        else if (pick < 42) op = OP_ADD;
        else if (pick < 71) op = OP_POINT;
        else                op = OP_SPHERE;
        // some degenerate triangles: repeated or collinear vertices
        if (op == OP_ADD && $urandom_range(9) == 0) begin
            for (int i = 0; i < 3; i++) begin
                p[6+i] = p[i];
                if ($urandom_range(1)) p[3+i] = p[i];
            end
        end
        send_item(op, p, pick_radius());
    endtask

    initial begin
        longint p[9];
        sb             = new();
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_op           = OP_CLEAR;
        {s_ax, s_ay, s_az, s_bx, s_by_coord, s_bz, s_cx, s_cy, s_cz} = '0;
        s_sphere_radius = '0;
        m_ready        = 1'b0;
        idle_cycles    = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, degenerate, extreme vertices, unit cube faces
        p = '{default: 0};
        send_item(OP_POINT, p, '0);
        send_item(OP_SPHERE, p, '1);
        send_item(OP_ADD, p, '0);
        p = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
              32'sh7fffffff, 32'sh7fffffff, 32'sh80000000};
        send_item(OP_ADD, p, '0);
        send_item(OP_POINT, p, '0);
        send_item(OP_CLEAR, p, '0);
        p = '{65536, 0, 0, 65536, 65536, 0, 65536, 0, 65536};
        send_item(OP_ADD, p, '0);
        p = '{-65536, 0, 0, -65536, 0, 65536, -65536, 65536, 0};
        send_item(OP_ADD, p, '0);
        p = '{default: 0};
        send_item(OP_POINT, p, '0);
        p[0] = 131072;
        send_item(OP_POINT, p, '0);
        send_item(OP_SPHERE, p, 31'd65536);
        send_item(OP_SPHERE, p, 31'd65535);
        send_item(OP_SPHERE, p, '1);
        // fill the table and overflow it
        for (int i = 0; i < 63; i++) begin
            for (int j = 0; j < 9; j++) p[j] = pick_coord();
            send_item(OP_ADD, p, '0);
        end
        send_item(OP_ADD, p, '0);
        send_item(OP_POINT, p, '0);
        send_item(OP_CLEAR, p, '0);

        // random phases with differing idle patterns
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 67; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 67; end
                default: begin src_idle_pct = 32; sink_stall_pct = 32; end
            endcase
            for (int i = 0; i < RANDOM_ITEMS / 4; i++) send_random_item();
        end
        s_valid <= 1'b0;

        // drain outstanding results
        while (sb.pending() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
